>>> rtl/shs_pkg.sv
// Shared types, constants and hash arithmetic for the streaming SuperFastHash block.
// No dependencies; imported by every module of the block.
`default_nettype none

package shs_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int TAIL_W = 24;

   // Number of bytes left over when the message ends
   localparam logic [1:0] TAIL_NONE  = 2'd0;
   localparam logic [1:0] TAIL_ONE   = 2'd1;
   localparam logic [1:0] TAIL_TWO   = 2'd2;
   localparam logic [1:0] TAIL_THREE = 2'd3;

   // One queued operation: seed, then one mixing round, then the finish
   typedef struct packed {
      logic              seed_en;
      logic [HASH_W-1:0] seed;
      logic              mix_en;
      logic [HASH_W-1:0] group;    // four bytes, byte 0 in bits 7:0
      logic              fin_en;
      logic [TAIL_W-1:0] tail;     // pending bytes, byte i at bits 8i
      logic [1:0]        tail_cnt;
   } op_type;

   function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
      return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
   endfunction

   function automatic logic [HASH_W-1:0] mix_group(input logic [HASH_W-1:0] h_i,
                                                   input logic [HASH_W-1:0] grp);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] t;
      h = h_i + {16'd0, grp[15:0]};
      t = ({16'd0, grp[31:16]} << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] tail_mix(input logic [HASH_W-1:0] h_i,
                                                  input logic [TAIL_W-1:0] tail,
                                                  input logic [1:0]        cnt);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] lo;
      h  = h_i;
      lo = {16'd0, tail[15:0]};
      case (cnt)
         TAIL_THREE: begin
            h = h + lo;
            h = h ^ (h << 16);
            h = h ^ (sext8(tail[23:16]) << 18);
            h = h + (h >> 11);
         end
         TAIL_TWO: begin
            h = h + lo;
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         TAIL_ONE: begin
            h = h + sext8(tail[7:0]);
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: begin
            h = h_i;
         end
      endcase
      return h;
   endfunction

   // First half of the avalanche
   function automatic logic [HASH_W-1:0] aval_lo(input logic [HASH_W-1:0] h_i);
      logic [HASH_W-1:0] h;
      h = h_i ^ (h_i << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      return h;
   endfunction

   // Second half of the avalanche
   function automatic logic [HASH_W-1:0] aval_hi(input logic [HASH_W-1:0] h_i);
      logic [HASH_W-1:0] h;
      h = h_i + (h_i >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

endpackage

`default_nettype wire

>>> rtl/superfast_hash_stream_top.sv
// Top level of the streaming 32-bit SuperFastHash block.
// Depends on shs_pkg, shs_front, shs_queue and shs_back.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid/ready, data_byte, has_byte,        | in
//           | first_item, last_item, msg_length            |
//   rsp     | rsp_valid/ready, hash_value                  | out
//
// One word is taken every cycle while the operation queue has room; the
// packer is combinational and a mixing round is applied as it is popped.
// A hash is offered once its last word has passed the queue, the tail
// stage and the two avalanche stages, the last of which loads the output
// register.
// Reset is synchronous and clears the packer, the running hash, the queue
// and all stage valids; no clearing pass is needed.
// A stalled result holds the avalanche stages, then the queue fills and
// req_ready drops; words that start no operation still need a free slot.
`default_nettype none

module superfast_hash_stream_top
   import shs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_has_byte,
   input  wire logic              req_first_item,
   input  wire logic              req_last_item,
   input  wire logic [HASH_W-1:0] req_msg_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [HASH_W-1:0]      rsp_hash_value
);

   // front end to queue
   logic   push_valid;
   logic   push_ready;
   op_type push_data;

   // queue to hash engine
   logic   pop_valid;
   logic   pop_ready;
   op_type pop_data;

   // Pack bytes into groups and issue seed, mix and finish operations
   shs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_first_item (req_first_item),
      .req_last_item  (req_last_item),
      .req_msg_length (req_msg_length),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // Decouple the packer from the hash engine
   shs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Advance the running hash; finish through tail and avalanche stages
   shs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

>>> rtl/shs_front.sv
// Front end: accepts byte items, packs bytes into groups of four and issues operations.
// Depends on shs_pkg.
`default_nettype none

module shs_front
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_has_byte,
   input  wire logic              req_first_item,
   input  wire logic              req_last_item,
   input  wire logic [HASH_W-1:0] req_msg_length,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output op_type                 push_data
);

   logic [TAIL_W-1:0] pend_ff, pend_in;
   logic [1:0]        cnt_ff,  cnt_in;
   logic [TAIL_W-1:0] pb;
   logic [1:0]        pc;
   logic              accept;
   op_type            op;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      // a new message drops whatever was pending
      pb = req_first_item ? '0 : pend_ff;
      pc = req_first_item ? TAIL_NONE : cnt_ff;

      op          = '0;
      op.seed_en  = req_first_item;
      op.seed     = req_msg_length;

      if (req_has_byte) begin
         if (pc == TAIL_THREE) begin
            op.mix_en = 1'b1;
            op.group  = {req_data_byte, pb};
            pb        = '0;
            pc        = TAIL_NONE;
         end else begin
            pb = pb | (TAIL_W'(req_data_byte) << {pc, 3'b000});
            pc = pc + 2'd1;
         end
      end

      op.fin_en   = req_last_item;
      op.tail     = pb;
      op.tail_cnt = pc;

      if (req_last_item) begin
         pend_in = '0;
         cnt_in  = TAIL_NONE;
      end else begin
         pend_in = pb;
         cnt_in  = pc;
      end
   end

   assign push_data  = op;
   assign push_valid = req_valid && (op.seed_en || op.mix_en || op.fin_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= TAIL_NONE;
      end else if (accept) begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/shs_queue.sv
// Short operation queue between the front end and the hash engine.
// Depends on shs_pkg.
`default_nettype none

module shs_queue
   import shs_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   output logic        push_ready,
   input  wire op_type push_data,
   output logic        pop_valid,
   input  wire logic   pop_ready,
   output op_type      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> rtl/shs_back.sv
// Hash engine: applies seed and mixing rounds, then runs tail and avalanche in stages.
// Depends on shs_pkg.
`default_nettype none

module shs_back
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire op_type            pop_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [HASH_W-1:0]      rsp_hash_value
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [HASH_W-1:0] s1_hash_ff;
   logic [TAIL_W-1:0] s1_tail_ff;
   logic [1:0]        s1_cnt_ff;
   logic              s2_valid_ff, s2_valid_in;
   logic [HASH_W-1:0] s2_hash_ff;
   logic              s3_valid_ff, s3_valid_in;
   logic [HASH_W-1:0] s3_hash_ff;
   logic              out_valid_ff, out_valid_in;
   logic [HASH_W-1:0] out_hash_ff;

   logic              s3_adv, s2_adv, s1_adv, s1_free;
   logic              do_pop, s1_load;
   logic [HASH_W-1:0] h_seed, h_mix;

   // stall chain, from the output back to the queue
   assign s3_adv  = s3_valid_ff && (!out_valid_ff || rsp_ready);
   assign s2_adv  = s2_valid_ff && (!s3_valid_ff || s3_adv);
   assign s1_adv  = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign s1_free = !s1_valid_ff || s1_adv;

   assign pop_ready = !pop_data.fin_en || s1_free;
   assign do_pop    = pop_valid && pop_ready;
   assign s1_load   = do_pop && pop_data.fin_en;

   always_comb begin
      h_seed = pop_data.seed_en ? pop_data.seed : hash_ff;
      h_mix  = pop_data.mix_en ? mix_group(h_seed, pop_data.group) : h_seed;

      hash_in = hash_ff;
      if (do_pop) begin
         hash_in = pop_data.fin_en ? '0 : h_mix;
      end

      s1_valid_in  = s1_load || (s1_valid_ff && !s1_adv);
      s2_valid_in  = s1_adv || (s2_valid_ff && !s2_adv);
      s3_valid_in  = s2_adv || (s3_valid_ff && !s3_adv);
      out_valid_in = s3_adv || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_hash_ff <= h_mix;
         s1_tail_ff <= pop_data.tail;
         s1_cnt_ff  <= pop_data.tail_cnt;
      end
      if (s1_adv) begin
         s2_hash_ff <= tail_mix(s1_hash_ff, s1_tail_ff, s1_cnt_ff);
      end
      if (s2_adv) begin
         s3_hash_ff <= aval_lo(s2_hash_ff);
      end
      if (s3_adv) begin
         out_hash_ff <= aval_hi(s3_hash_ff);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

`ifndef SYNTHESIS
   a_hash_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_load |=> (hash_ff == '0))
      else $error("running hash not cleared after finish");

   a_s1_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_load |-> s1_free)
      else $error("finish loaded into occupied tail stage");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_hash_ff)))
      else $error("stalled tail stage lost its contents");
`endif

endmodule

`default_nettype wire

>>> test/shs_checker.sv
// Scoreboard for the streaming SuperFastHash block: watches both channels,
// predicts each hash from the accepted words and compares it. Depends on shs_pkg.
module shs_checker
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_has_byte,
   input  wire logic              req_first_item,
   input  wire logic              req_last_item,
   input  wire logic [HASH_W-1:0] req_msg_length,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [HASH_W-1:0] rsp_hash_value,
   output int                     fail_total,
   output int                     hashes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [HASH_W-1:0] acc_hash;
   logic [TAIL_W-1:0] held_bytes;
   logic [1:0]        held_count;
   logic [HASH_W-1:0] pending_hashes[$];

   function automatic logic [HASH_W-1:0] fold_group(input logic [HASH_W-1:0] h,
                                                    input logic [15:0]       lo,
                                                    input logic [15:0]       hi);
      logic [HASH_W-1:0] t;
      h = h + {16'h0, lo};
      t = {5'h0, hi, 11'h0} ^ h;
      h = {h[15:0], 16'h0} ^ t;
      h = h + {11'h0, h[31:11]};
      return h;
   endfunction

   // tail rule on the leftover bytes, then the six-step avalanche
   function automatic logic [HASH_W-1:0] close_hash(input logic [HASH_W-1:0] h,
                                                    input logic [TAIL_W-1:0] held,
                                                    input logic [1:0]        cnt);
      logic [7:0] b0;
      logic [7:0] b2;
      b0 = held[7:0];
      b2 = held[23:16];
      case (cnt)
         TAIL_THREE: begin
            h = h + {16'h0, held[15:0]};
            h = h ^ {h[15:0], 16'h0};
            h = h ^ {{6{b2[7]}}, b2, 18'h0};
            h = h + (h >> 11);
         end
         TAIL_TWO: begin
            h = h + {16'h0, held[15:0]};
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         TAIL_ONE: begin
            h = h + {{24{b0[7]}}, b0};
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: begin
         end
      endcase
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

   task automatic predict_word();
      if (req_first_item) begin
         acc_hash   = req_msg_length;
         held_bytes = '0;
         held_count = TAIL_NONE;
      end
      if (req_has_byte) begin
         if (held_count == TAIL_THREE) begin
            acc_hash   = fold_group(acc_hash, held_bytes[15:0],
                                    {req_data_byte, held_bytes[23:16]});
            held_bytes = '0;
            held_count = TAIL_NONE;
         end else begin
            held_bytes[8*held_count +: 8] = req_data_byte;
            held_count = held_count + 2'd1;
         end
      end
      if (req_last_item) begin
         pending_hashes.push_back(close_hash(acc_hash, held_bytes, held_count));
         acc_hash   = '0;
         held_bytes = '0;
         held_count = TAIL_NONE;
      end
   endtask

   initial begin
      fail_total  = 0;
      hashes_owed = 0;
   end

   always @(posedge clock) begin
      logic [HASH_W-1:0] want;
      if (reset) begin
         acc_hash   = '0;
         held_bytes = '0;
         held_count = TAIL_NONE;
         pending_hashes.delete();
      end else begin
         if (req_valid && req_ready)
            predict_word();
         if (rsp_valid && rsp_ready) begin
            if (pending_hashes.size() == 0) begin
               $error("hash_value: none expected, got %h", rsp_hash_value);
               fail_total = fail_total + 1;
            end else begin
               want = pending_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %h, got %h", want, rsp_hash_value);
                  fail_total = fail_total + 1;
               end
            end
         end
      end
      hashes_owed = pending_hashes.size();
   end

endmodule

>>> test/testbench.sv
// Top of the SuperFastHash stream testbench: clock, reset, word stimulus,
// result back-pressure and verdict. Depends on shs_pkg, shs_checker and the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import shs_pkg::*;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic [BYTE_W-1:0] req_data_byte  = '0;
   logic              req_has_byte   = 1'b0;
   logic              req_first_item = 1'b0;
   logic              req_last_item  = 1'b0;
   logic [HASH_W-1:0] req_msg_length = '0;
   logic              rsp_ready      = 1'b0;
   wire               req_ready;
   wire               rsp_valid;
   wire  [HASH_W-1:0] rsp_hash_value;

   int         check_fails;
   int         hashes_owed;
   int         words_sent = 0;
   bit         gaps_off   = 1'b0;
   logic [7:0] msg_bytes[$];

   // result side stall state
   int         ready_stall = 0;
   int         cycle_no    = 0;

   always #5 clock = ~clock;

   superfast_hash_stream_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_first_item (req_first_item),
      .req_last_item  (req_last_item),
      .req_msg_length (req_msg_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   shs_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_first_item (req_first_item),
      .req_last_item  (req_last_item),
      .req_msg_length (req_msg_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .fail_total     (check_fails),
      .hashes_owed    (hashes_owed)
   );

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 50);
   endfunction

   // Result back-pressure. While cycle_no % 1500 is below 300 no new stall
   // starts; otherwise drop rsp_ready for random stretches so that
   // stalls hit the avalanche stages and, when long, fill the queue.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (ready_stall > 0) begin
         rsp_ready   <= 1'b0;
         ready_stall <= ready_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ((cycle_no % 1500) >= 300 && $urandom_range(0, 3) == 0)
            ready_stall <= idle_cycles();
      end
   end

   // Present one word and hold it until taken. Valid is only dropped for a
   // gap before a word, so back-to-back words keep it high without a glitch.
   task automatic send_word(input logic [7:0]  data,
                            input logic        has,
                            input logic        first,
                            input logic        last,
                            input logic [31:0] len);
      int gap;
      gap = gaps_off ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_has_byte   <= has;
      req_first_item <= first;
      req_last_item  <= last;
      req_msg_length <= len;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Send msg_bytes as one message. An empty message is a single word with
   // no byte. Words after the first carry a junk length, which must be
   // ignored; byteless filler words are slipped in at blank_pct percent.
   task automatic send_message(input logic [31:0] len,
                               input bit          use_first,
                               input int          blank_pct);
      int n;
      n = msg_bytes.size();
      if (n == 0) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, use_first, 1'b1, len);
      end else begin
         for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 99) < blank_pct)
               send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, $urandom);
            send_word(msg_bytes[i], 1'b1, use_first && i == 0, i == n - 1,
                      (i == 0) ? len : $urandom);
         end
      end
   endtask

   task automatic fill_bytes(input int n);
      msg_bytes.delete();
      repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int kind;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty messages: avalanche of the seed alone, both length extremes.
      msg_bytes.delete();
      send_message(32'h0000_0000, 1'b1, 0);
      send_message(32'hFFFF_FFFF, 1'b1, 0);
      // Single tail byte with its top bit set: sign extension.
      msg_bytes = '{8'h80};
      send_message(32'd1, 1'b1, 0);
      // Two-byte tail, bytes at both extremes.
      msg_bytes = '{8'hFF, 8'h00};
      send_message(32'd2, 1'b1, 0);
      // Three-byte tail, odd third byte negative.
      msg_bytes = '{8'h01, 8'h02, 8'hFF};
      send_message(32'd3, 1'b1, 0);
      // Exactly one full group, no tail.
      msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message(32'd4, 1'b1, 0);
      // Length disagrees with the bytes sent: tail follows the bytes.
      msg_bytes = '{8'h00, 8'h55, 8'hAA, 8'h12, 8'h7F};
      send_message(32'd1000, 1'b1, 0);
      // No first word: carry on from the cleared state.
      msg_bytes = '{8'hC3, 8'h3C};
      send_message(32'd2, 1'b0, 0);
      // Byteless words: as first, in the middle and as last.
      send_word(8'hA5, 1'b0, 1'b1, 1'b0, 32'd3);
      send_word(8'h81, 1'b1, 1'b0, 1'b0, 32'd0);
      send_word(8'h5A, 1'b0, 1'b0, 1'b0, 32'd0);
      send_word(8'hFE, 1'b1, 1'b0, 1'b0, 32'd0);
      send_word(8'h00, 1'b0, 1'b0, 1'b1, 32'd0);

      // Random part: mostly well-formed messages with random content.
      while (words_sent < 1580) begin
         kind     = $urandom_range(0, 99);
         gaps_off = ($urandom_range(0, 4) == 0);
         n        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(0, 12);
         fill_bytes(n);
         if (kind < 75) begin
            send_message(n, 1'b1, 3);
         end else if (kind < 83) begin
            send_message($urandom, 1'b1, 10);
         end else if (kind < 88) begin
            send_message(n, 1'b0, 0);
         end else begin
            // noise: words with every field at random, restarts mid-message
            repeat ($urandom_range(1, 6))
               send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                         $urandom);
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed hash, then let the pipeline settle.
      @(posedge clock);
      while (hashes_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (check_fails == 0)
         $display("** superfast_hash_stream_top: PASSED **");
      else
         $display("** superfast_hash_stream_top: FAILED **");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("** superfast_hash_stream_top: FAILED **");
      $finish;
   end

endmodule
